FILE: rtl/tgad_pkg.sv
package tgad_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int BPP_W      = 8;
    localparam int DIM_W      = 16;
    localparam int PROD_W     = 2 * DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd3;

    localparam logic [BPP_W-1:0] BPP_16 = 8'd16;
    localparam logic [BPP_W-1:0] BPP_24 = 8'd24;
    localparam logic [BPP_W-1:0] BPP_32 = 8'd32;

    localparam logic [7:0] RUN_HEADER_MIN = 8'd128;
    localparam logic [7:0] RUN_BIAS       = 8'd127;

    // largest pixel count, held in the product width
    localparam logic [PROD_W-1:0] COUNT_MAX =
        PROD_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    typedef struct packed {
        logic                   rle_enable;
        logic [BPP_W-1:0]       bits_per_pixel;
        logic [COUNT_WIDTH-1:0] total_pixels;
        logic                   restart;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] run_length;
    } pixel_t;

endpackage

FILE: rtl/tgad_cfg.sv
module tgad_cfg
    import tgad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic                   rle_reg, rle_next;
    logic [BPP_W-1:0]       bpp_reg, bpp_next;
    logic [DIM_W-1:0]       width_reg, width_next;
    logic [DIM_W-1:0]       height_reg, height_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [PROD_W-1:0]      product;
    logic [DIM_W-1:0]       mul_a, mul_b;

    always_comb begin
        rle_next    = rle_reg;
        bpp_next    = bpp_reg;
        width_next  = width_reg;
        height_next = height_reg;
        mul_a       = width_reg;
        mul_b       = height_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_RLE_ENABLE:     rle_next = cfg_data[0];
                REG_BITS_PER_PIXEL: bpp_next = cfg_data[BPP_W-1:0];
                REG_IMAGE_WIDTH: begin
                    width_next = cfg_data[DIM_W-1:0];
                    mul_a      = cfg_data[DIM_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    height_next = cfg_data[DIM_W-1:0];
                    mul_b       = cfg_data[DIM_W-1:0];
                end
                default: ;
            endcase
        end
        // pixel count of the image, saturated, an empty image counts as one pixel
        product = mul_a * mul_b;
        if (product > COUNT_MAX) begin
            total_next = COUNT_MAX[COUNT_WIDTH-1:0];
        end else if (product == '0) begin
            total_next = COUNT_WIDTH'(1);
        end else begin
            total_next = product[COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rle_reg    <= 1'b0;
            bpp_reg    <= BPP_24;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            total_reg  <= COUNT_WIDTH'(1);
        end else begin
            rle_reg    <= rle_next;
            bpp_reg    <= bpp_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            total_reg  <= total_next;
        end
    end

    assign cfg.rle_enable     = rle_reg;
    assign cfg.bits_per_pixel = bpp_reg;
    assign cfg.total_pixels   = total_reg;
    assign cfg.restart        = cfg_we;

endmodule

FILE: rtl/tgad_core.sv
module tgad_core
    import tgad_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_take,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_t     out_pixel,
    output logic       out_last,
    output logic       out_error
);

    logic                   in_packet_reg, in_packet_next;
    logic                   run_packet_reg, run_packet_next;
    logic [7:0]             packet_left_reg, packet_left_next;
    logic [1:0]             byte_pos_reg, byte_pos_next;
    logic [7:0]             color_reg [4];
    logic [COUNT_WIDTH-1:0] pixels_left_reg, pixels_left_next;

    logic                   out_valid_reg, out_valid_next;
    pixel_t                 pixel_reg, pixel_next;
    logic                   last_reg, last_next;
    logic                   error_reg, error_next;

    logic                   fire;
    logic                   fmt_ok;
    logic [1:0]             last_pos;
    logic [7:0]             col [4];
    logic [COUNT_WIDTH-1:0] pl, pl_after;
    logic [COUNT_WIDTH-1:0] run_cnt;
    logic [7:0]             packet_dec;
    logic [15:0]            p16;

    assign fire    = in_valid && (!out_valid_reg || out_ready);
    assign in_take = fire;

    assign fmt_ok = (cfg.bits_per_pixel == BPP_24) || (cfg.bits_per_pixel == BPP_32) ||
                    ((cfg.bits_per_pixel == BPP_16) && !cfg.rle_enable);

    always_comb begin
        last_pos = 2'd2;
        if (cfg.bits_per_pixel == BPP_16) begin
            last_pos = 2'd1;
        end else if (cfg.bits_per_pixel == BPP_32) begin
            last_pos = 2'd3;
        end
        for (int i = 0; i < 4; i++) begin
            col[i] = (byte_pos_reg == 2'(i)) ? in_byte : color_reg[i];
        end
    end

    always_comb begin
        in_packet_next   = in_packet_reg;
        run_packet_next  = run_packet_reg;
        packet_left_next = packet_left_reg;
        byte_pos_next    = byte_pos_reg;
        pixels_left_next = pixels_left_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        pixel_next       = pixel_reg;
        last_next        = last_reg;
        error_next       = error_reg;

        // image start loads the pixel count
        pl = (pixels_left_reg == '0) ? cfg.total_pixels : pixels_left_reg;
        run_cnt = COUNT_WIDTH'(packet_left_reg);
        if (run_cnt > pl) begin
            run_cnt = pl;
        end
        pl_after   = pl - COUNT_WIDTH'(1);
        packet_dec = packet_left_reg - 8'd1;
        p16        = {col[1], col[0]};

        if (cfg.restart) begin
            in_packet_next   = 1'b0;
            run_packet_next  = 1'b0;
            packet_left_next = '0;
            byte_pos_next    = '0;
            pixels_left_next = '0;
        end else if (fire) begin
            if (!fmt_ok) begin
                out_valid_next = 1'b1;
                pixel_next     = '0;
                last_next      = 1'b0;
                error_next     = 1'b1;
            end else begin
                pixels_left_next = pl;
                if (cfg.rle_enable && !in_packet_reg) begin
                    // packet header
                    in_packet_next = 1'b1;
                    byte_pos_next  = '0;
                    if (in_byte < RUN_HEADER_MIN) begin
                        run_packet_next  = 1'b0;
                        packet_left_next = in_byte + 8'd1;
                    end else begin
                        run_packet_next  = 1'b1;
                        packet_left_next = in_byte - RUN_BIAS;
                    end
                end else if (byte_pos_reg != last_pos) begin
                    byte_pos_next = byte_pos_reg + 2'd1;
                end else begin
                    byte_pos_next  = '0;
                    out_valid_next = 1'b1;
                    error_next     = 1'b0;
                    if (cfg.bits_per_pixel == BPP_16) begin
                        pixel_next.red   = {p16[14:10], 3'b000};
                        pixel_next.green = {p16[9:5], 3'b000};
                        pixel_next.blue  = {p16[4:0], 3'b000};
                        pixel_next.alpha = '0;
                    end else begin
                        pixel_next.red   = col[2];
                        pixel_next.green = col[1];
                        pixel_next.blue  = col[0];
                        pixel_next.alpha = (cfg.bits_per_pixel == BPP_32) ? col[3] : 8'd0;
                    end
                    if (cfg.rle_enable && run_packet_reg) begin
                        // repeated colour, clipped to what is left of the image
                        pixel_next.run_length = run_cnt[7:0];
                        pixels_left_next      = pl - run_cnt;
                        last_next             = (pl == run_cnt);
                        in_packet_next        = 1'b0;
                        packet_left_next      = '0;
                    end else begin
                        pixel_next.run_length = 8'd1;
                        pixels_left_next      = pl_after;
                        last_next             = (pl_after == '0);
                        if (cfg.rle_enable) begin
                            packet_left_next = packet_dec;
                            if (packet_dec == '0 || pl_after == '0) begin
                                in_packet_next   = 1'b0;
                                packet_left_next = '0;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg   <= 1'b0;
            run_packet_reg  <= 1'b0;
            packet_left_reg <= '0;
            byte_pos_reg    <= '0;
            pixels_left_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            in_packet_reg   <= in_packet_next;
            run_packet_reg  <= run_packet_next;
            packet_left_reg <= packet_left_next;
            byte_pos_reg    <= byte_pos_next;
            pixels_left_reg <= pixels_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pixel_reg <= pixel_next;
        last_reg  <= last_next;
        error_reg <= error_next;
        if (fire && fmt_ok && !(cfg.rle_enable && !in_packet_reg) && !cfg.restart) begin
            color_reg[byte_pos_reg] <= in_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = pixel_reg;
    assign out_last  = last_reg;
    assign out_error = error_reg;

endmodule

FILE: rtl/tga_pixel_stream_decoder.sv
// TGA pixel data decoder.
// Software parses the file header and writes the mode, depth and image size through
// the configuration port (index 0 rle enable, 1 bits per pixel, 2 width, 3 height);
// any write restarts decoding at the start of an image.
// The slave channel takes one byte of the pixel data section per transfer. The master
// channel gives one decoded pixel per complete pixel: tdata holds red, green, blue,
// alpha and run length, tlast marks the pixel that completes the image and tuser
// flags an unsupported depth or mode (every byte then gives an error transfer).
// Packet headers and partial pixels give no transfer; an RLE run packet gives one
// transfer with its run length, clipped to the pixels still left.
// A byte taken is held in the input register and its result is written to the output
// register when the decode stage takes the byte from there.
// Throughput: one byte per cycle unless the receiver stalls, set by the single decode
// stage between the input and output registers; its state is updated once per byte.
// When the receiver stalls, the result holds in the output register and one more byte
// waits in the input register before s_tready drops.
// Reset clears the decode state and the valid flags and loads the register defaults
// (uncompressed, 24 bits, one by one image).
module tga_pixel_stream_decoder
    import tgad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // red, green, blue, alpha, run_length
    output logic                  m_tlast,   // last_pixel
    output logic                  m_tuser    // format_error
);

    cfg_t       cfg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       take;
    pixel_t     pixel;

    assign s_tready = !in_valid_reg || take;

    always_comb begin
        in_valid_next = in_valid_reg && !take;
        in_byte_next  = in_byte_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
    end

    tgad_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tgad_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .in_take   (take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (pixel),
        .out_last  (m_tlast),
        .out_error (m_tuser)
    );

    assign m_tdata = {pixel.run_length, pixel.alpha, pixel.blue, pixel.green, pixel.red};

endmodule

FILE: sim/tga_pixel_checker.sv
module tga_pixel_checker
    import tgad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,   // red, green, blue, alpha, run_length
    input  logic                  m_tlast,   // last_pixel
    input  logic                  m_tuser,   // format_error
    output int                    mismatches,
    output int                    outstanding,
    output int                    pixels_out,
    output int                    format_errors
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] run_length;
        logic       last;
        logic       err;
    } decoded_t;

    // decoder copy: registers
    logic             rle_on;
    logic [BPP_W-1:0] depth;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;

    // decoder copy: stream state
    logic            in_packet;
    logic            run_packet;
    logic [7:0]      packet_left;
    logic [1:0]      byte_pos;
    logic [7:0]      colour [4];
    longint unsigned pixels_left;

    decoded_t pending_pixels [$];
    int       n_bad;
    int       n_pix;
    int       n_err;

    function automatic void restart_image();
        in_packet   = 1'b0;
        run_packet  = 1'b0;
        packet_left = '0;
        byte_pos    = '0;
        pixels_left = 0;
    endfunction

    function automatic string describe(input decoded_t px);
        return $sformatf("r=%02h g=%02h b=%02h a=%02h run=%0d last=%b err=%b",
                         px.red, px.green, px.blue, px.alpha, px.run_length, px.last, px.err);
    endfunction

    function automatic decoded_t colour_out(input logic [7:0] run, input logic last);
        decoded_t    px;
        logic [15:0] p;
        px = '0;
        p  = {colour[1], colour[0]};
        if (depth == BPP_16) begin
            // 5-5-5 little endian, each field widened by three zero bits
            px.red   = {p[14:10], 3'b000};
            px.green = {p[9:5], 3'b000};
            px.blue  = {p[4:0], 3'b000};
        end else begin
            px.red   = colour[2];
            px.green = colour[1];
            px.blue  = colour[0];
            if (depth == BPP_32) px.alpha = colour[3];
        end
        px.run_length = run;
        px.last       = last;
        return px;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output decoded_t px);
        longint unsigned n;
        logic [7:0]      run;
        px = '0;
        if (!(depth == BPP_24 || depth == BPP_32 || (depth == BPP_16 && !rle_on))) begin
            px.err = 1'b1;
            return 1'b1;
        end
        if (pixels_left == 0) begin
            n = longint'(width) * longint'(height);
            if (n > COUNT_MAX) n = COUNT_MAX;
            if (n == 0) n = 1;
            pixels_left = n;
        end
        if (rle_on && !in_packet) begin
            if (b < RUN_HEADER_MIN) begin
                run_packet  = 1'b0;
                packet_left = b + 8'd1;
            end else begin
                run_packet  = 1'b1;
                packet_left = b - RUN_BIAS;
            end
            in_packet = 1'b1;
            byte_pos  = '0;
            return 1'b0;
        end
        colour[byte_pos] = b;
        if (int'(byte_pos) + 1 < int'(depth) / 8) begin
            byte_pos = byte_pos + 2'd1;
            return 1'b0;
        end
        byte_pos = '0;
        if (!rle_on) begin
            pixels_left--;
            px = colour_out(8'd1, pixels_left == 0);
            return 1'b1;
        end
        if (run_packet) begin
            run = packet_left;
            if (run > pixels_left) run = pixels_left[7:0];
            pixels_left -= run;
            in_packet   = 1'b0;
            packet_left = '0;
            px = colour_out(run, pixels_left == 0);
            return 1'b1;
        end
        pixels_left--;
        packet_left = packet_left - 8'd1;
        // raw packet ends on its own count or with the image
        if (packet_left == 0 || pixels_left == 0) begin
            in_packet   = 1'b0;
            packet_left = '0;
        end
        px = colour_out(8'd1, pixels_left == 0);
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : monitor
        decoded_t want;
        decoded_t got;
        int       i;
        if (!aresetn) begin
            rle_on = 1'b0;
            depth  = BPP_24;
            width  = 16'd1;
            height = 16'd1;
            for (i = 0; i < 4; i++) colour[i] = '0;
            restart_image();
            pending_pixels.delete();
            n_bad = 0;
            n_pix = 0;
            n_err = 0;
        end else begin
            // result side first, so a result cannot match a byte taken at the same edge
            if (m_tvalid && m_tready) begin
                got.red        = m_tdata[7:0];
                got.green      = m_tdata[15:8];
                got.blue       = m_tdata[23:16];
                got.alpha      = m_tdata[31:24];
                got.run_length = m_tdata[39:32];
                got.last       = m_tlast;
                got.err        = m_tuser;
                if (got.err) n_err++;
                else n_pix++;
                if (pending_pixels.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected result transfer: %s", describe(got));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("pixel mismatch at %0t: expected %s, got %s",
                                     $realtime, describe(want), describe(got));
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_RLE_ENABLE:     rle_on = cfg_data[0];
                    REG_BITS_PER_PIXEL: depth  = cfg_data[BPP_W-1:0];
                    REG_IMAGE_WIDTH:    width  = cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT:   height = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
                restart_image();
            end
            if (s_tvalid && s_tready) begin
                if (decode_byte(s_tdata, want)) pending_pixels.push_back(want);
            end
        end
        mismatches    <= n_bad;
        outstanding   <= pending_pixels.size();
        pixels_out    <= n_pix;
        format_errors <= n_err;
    end

endmodule

FILE: sim/tb.sv
module tb;
    import tgad_pkg::*;

    localparam int ITEM_TARGET    = 1050;
    localparam int HOLD_FROM      = 400;
    localparam int CALM_FROM      = 880;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int mismatches;
    int outstanding;
    int pixels_out;
    int format_errors;

    int  bytes_sent  = 0;
    int  settings    = 0;
    int  idle_cycles = 0;
    bit  gappy       = 1'b0;
    bit  hold_sink   = 1'b0;
    logic calm;

    logic             cur_rle = 1'b0;
    logic [BPP_W-1:0] cur_bpp = BPP_24;
    logic [DIM_W-1:0] cur_w   = 16'd1;
    logic [DIM_W-1:0] cur_h   = 16'd1;

    assign calm = bytes_sent >= CALM_FROM;

    tga_pixel_stream_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    tga_pixel_checker pixel_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .pixels_out    (pixels_out),
        .format_errors (format_errors)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // nothing moving on either channel for too long means the block is stuck
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, outstanding);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gappy && !calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_pixel(input int nb);
        repeat (nb) send_byte(8'($urandom_range(0, 255)));
    endtask

    // sender pauses until every result is out and the pipeline has emptied
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic rle, input logic [BPP_W-1:0] bpp,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RLE_ENABLE;
        cfg_data  <= CFG_DATA_W'(rle);
        @(posedge aclk);
        cfg_index <= REG_BITS_PER_PIXEL;
        cfg_data  <= CFG_DATA_W'(bpp);
        @(posedge aclk);
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_rle = rle;
        cur_bpp = bpp;
        cur_w   = w;
        cur_h   = h;
        settings++;
    endtask

    task automatic pick_config();
        logic             r;
        logic [BPP_W-1:0] bpp;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int               shape;
        r = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       bpp = BPP_W'($urandom_range(0, 255));
            1, 2, 3: bpp = BPP_16;
            4, 5, 6: bpp = BPP_24;
            default: bpp = BPP_32;
        endcase
        shape = $urandom_range(0, 15);
        if (shape == 0) begin
            w = 16'hffff;
            h = DIM_W'($urandom_range(1, 65535));
        end else if (shape == 1) begin
            w = DIM_W'($urandom_range(1, 65535));
            h = 16'hffff;
        end else if (shape == 2) begin
            // zero area is decoded as a single pixel
            w = '0;
            h = DIM_W'($urandom_range(0, 3));
        end else begin
            w = DIM_W'($urandom_range(1, 6));
            h = DIM_W'($urandom_range(1, 4));
        end
        configure(r, bpp, w, h);
    endtask

    task automatic random_image();
        longint unsigned total;
        longint unsigned left;
        int              nb;
        int              cnt;
        int              npk;
        if (!(cur_bpp == BPP_24 || cur_bpp == BPP_32 || (cur_bpp == BPP_16 && !cur_rle))) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        nb    = int'(cur_bpp) / 8;
        total = longint'(cur_w) * longint'(cur_h);
        if (total == 0) total = 1;
        if (!cur_rle) begin
            cnt = total > 24 ? $urandom_range(1, 24) : int'(total);
            repeat (cnt) send_pixel(nb);
            // partial pixel left hanging, dropped by the next register write
            if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        left = total;
        npk  = 0;
        while (left != 0 && npk < 24 && bytes_sent < ITEM_TARGET) begin
            npk++;
            if ($urandom_range(0, 1) == 1) begin
                cnt = $urandom_range(0, 5) == 0 ? $urandom_range(1, 128) : $urandom_range(1, 8);
                send_byte(8'(int'(RUN_BIAS) + cnt));
                send_pixel(nb);
            end else begin
                cnt = $urandom_range(0, 39) == 0 ? $urandom_range(1, 128) : $urandom_range(1, 6);
                send_byte(8'(cnt - 1));
                repeat (cnt) send_pixel(nb);
            end
            // a raw packet longer than the image spills into the next one, a run is clipped
            left = cnt >= left ? 0 : left - cnt;
        end
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin : receiver
        bit held;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_sink && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    initial begin : stimulus
        bit hold_done;
        hold_done = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: uncompressed 24-bit, one pixel image
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hff);

        // unsupported depths, and compressed 16-bit
        settle();
        configure(1'b0, 8'd0, 16'd1, 16'd1);
        send_byte(8'h5a);
        settle();
        configure(1'b0, 8'd255, 16'd1, 16'd1);
        send_byte(8'ha5);
        settle();
        configure(1'b1, BPP_16, 16'd1, 16'd1);
        send_byte(8'hff);

        // 5-5-5 with every field at full scale, then only the unused top bit
        settle();
        configure(1'b0, BPP_16, 16'd1, 16'd2);
        send_byte(8'hff);
        send_byte(8'h7f);
        send_byte(8'h00);
        send_byte(8'h80);

        // raw packet of three on a two pixel image, then a 128 run clipped to two
        settle();
        configure(1'b1, BPP_24, 16'd2, 16'd1);
        send_byte(8'h02);
        send_pixel(3);
        send_pixel(3);
        send_byte(8'hff);
        send_pixel(3);

        // largest image, longest run
        settle();
        configure(1'b1, BPP_32, 16'hffff, 16'hffff);
        send_byte(8'hff);
        send_pixel(4);

        // zero width
        settle();
        configure(1'b0, BPP_24, 16'd0, 16'd7);
        send_pixel(3);

        while (bytes_sent < ITEM_TARGET || !hold_done) begin
            settle();
            if (!hold_done && bytes_sent >= HOLD_FROM) begin
                // long receiver stall with the sender still pushing
                hold_done = 1'b1;
                gappy     = 1'b0;
                configure(1'b0, BPP_24, 16'd64, 16'd1);
                hold_sink <= 1'b1;
                repeat (64) send_pixel(3);
            end else begin
                pick_config();
                gappy = 1'($urandom_range(0, 1));
                random_image();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("fed %0d pixel data bytes under %0d register settings", bytes_sent, settings);
        $display("checked %0d decoded pixel transfers and %0d format error transfers",
                 pixels_out, format_errors);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tgad_pkg.sv
rtl/tgad_cfg.sv
rtl/tgad_core.sv
rtl/tga_pixel_stream_decoder.sv
sim/tga_pixel_checker.sv
sim/tb.sv
